FILE: rtl/hbrf_pkg.sv
// Shared constants, types and the exponential table builder for the histogram range fusion block.
package hbrf_pkg;

    localparam int BIN_COUNT   = 131;
    localparam int EXP_ENTRIES = 1024;
    localparam int WEIGHT_BITS = 24;

    localparam int ECHO_W  = 15;
    localparam int DIST_W  = 11;
    localparam int SIGMA_W = 16;
    localparam int EST_W   = 11;

    localparam int DIST_LOW   = 200;
    localparam int DIST_HIGH  = 1500;
    localparam int BIN_PITCH  = 10;
    localparam int EST_MAX    = 2047;
    localparam int ECHO_SCALE = 1715;
    localparam int ECHO_ROUND = 500;
    localparam int ECHO_DIV   = 1000;
    localparam int DEN_SCALE  = 625;
    localparam int EXP_NUM_SHIFT = 21;

    // Division by ECHO_DIV as a multiplication by ceil(2^36 / 1000) and a shift by 36. The
    // result is exact for every numerator below 2^36 / 264, far above the largest echo product.
    localparam int DIST_RECIP       = 68719477;
    localparam int DIST_RECIP_SHIFT = 36;

    localparam int BIN_IDX_W = $clog2(BIN_COUNT);
    localparam int X_MAX     = DIST_LOW + BIN_PITCH * (BIN_COUNT - 1);
    localparam int X_W       = ($clog2(X_MAX + 1) > DIST_W) ? $clog2(X_MAX + 1) : DIST_W;
    localparam int DDSQ_W    = 2 * X_W;
    localparam int SQ_W      = 2 * SIGMA_W;
    localparam int DEN_W     = SQ_W + 10;

    localparam int EXP_CAP_W  = $clog2(EXP_ENTRIES + 1);
    localparam int EXP_SUM_W  = EXP_CAP_W + 1;
    localparam int EXP_ADDR_W = $clog2(EXP_ENTRIES);
    localparam int EXP_VAL_W  = 31;

    localparam int WEIGHT_W = WEIGHT_BITS + 1;
    localparam int TOTAL_W  = WEIGHT_W + BIN_IDX_W;
    localparam int SUM_W    = X_W + WEIGHT_BITS + BIN_IDX_W + 1;

    localparam int DIST_QBITS = 16;
    localparam int QUO_W      = (WEIGHT_W > DIST_QBITS) ? WEIGHT_W : DIST_QBITS;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
    localparam int EXP_NUM_W  = DDSQ_W + EXP_CAP_W + EXP_NUM_SHIFT + 1;
    localparam int NORM_DIV_W = TOTAL_W + WEIGHT_BITS + 1;
    localparam int DIV_W      = (EXP_NUM_W > NORM_DIV_W) ? EXP_NUM_W : NORM_DIV_W;

    localparam int UNIFORM_W = (1 << WEIGHT_BITS) / BIN_COUNT;
    localparam int W_MAX     = (1 << WEIGHT_BITS) - 1;

    localparam logic [SIGMA_W-1:0] SIGMA_START_RST = 16'd13107;
    localparam logic [SIGMA_W-1:0] SIGMA_FLOOR_RST = 16'd6554;
    localparam logic [SIGMA_W-1:0] SIGMA_CEIL_RST  = 16'd32768;
    localparam logic [SIGMA_W-1:0] WIDEN_RST       = 16'd36045;
    localparam logic [SIGMA_W-1:0] NARROW_RST      = 16'd29491;

    localparam logic [2:0] CFG_SIGMA_START = 3'd0;
    localparam logic [2:0] CFG_SIGMA_FLOOR = 3'd1;
    localparam logic [2:0] CFG_SIGMA_CEIL  = 3'd2;
    localparam logic [2:0] CFG_WIDEN       = 3'd3;
    localparam logic [2:0] CFG_NARROW      = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIST_GO, ST_DIST_WAIT, ST_SIG_MUL, ST_SIG_SET, ST_SQ, ST_DEN,
        ST_B_DD, ST_B_NUM, ST_B_GO, ST_B_WAIT, ST_B_ROM, ST_B_MUL, ST_B_WR, ST_TOT,
        ST_N_RD, ST_N_GO, ST_N_WAIT, ST_E_RD, ST_E_ACC, ST_EST, ST_OUT
    } hbrf_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] qbits;
    } div_ctl_t;

    typedef logic [EXP_VAL_W-1:0] exp_rom_t [EXP_ENTRIES];

    // exp(-f) for f in Q0.30, Taylor series truncated after the term of order 24.
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        longint      sum_v;
        logic [63:0] term;
        sum_v = longint'(64'd1 << 30);
        term  = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if ((k % 2) == 1) begin
                sum_v = sum_v - longint'(term);
            end else begin
                sum_v = sum_v + longint'(term);
            end
        end
        return (sum_v < 0) ? 64'd0 : 64'(sum_v);
    endfunction

    // Entry k holds exp(-16k/EXP_ENTRIES) in Q0.30.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] e1;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] v;
        e1 = exp_neg_frac(64'd1 << 30);
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            t = (64'(k) << 34) / EXP_ENTRIES;
            n = t >> 30;
            v = exp_neg_frac(t & ((64'd1 << 30) - 64'd1));
            for (int j = 0; j < 16; j++) begin
                if (64'(j) < n) begin
                    v = (v * e1 + (64'd1 << 29)) >> 30;
                end
            end
            rom[k] = v[EXP_VAL_W-1:0];
        end
        return rom;
    endfunction

endpackage

FILE: rtl/histogram_bayes_range_fusion.sv
// Two-sensor discrete Bayes histogram filter that fuses ultrasonic ranges into one estimate.
//
// Each input beat carries two echo widths in microseconds. They become distances in hundredths
// of a centimeter clamped to 200..1500, the two sigmas are scaled and bounded, every bin of the
// belief is weighted by a Gaussian factor from an exponential table, the belief is renormalized
// and the expected distance goes out in one result beat together with the first sigma and a flag
// that reports a collapse to the uniform belief. The block works on one beat at a time. An item
// goes through a setup of the distances, sigmas and denominators, a weighting pass over the
// bins set mostly by the 11-bit exponent divisions, a renormalization pass over the bins set
// by the 25-bit division of each weight by the total, and an estimate pass over the bins.
// When the total weight is zero the renormalization pass is skipped. Both the belief and the
// weights of the current item live in single-port memories with registered reads; after reset
// the belief reads as uniform without a clearing pass. The next input beat is taken as soon as
// a finished result sits in the output register.
module histogram_bayes_range_fusion
    import hbrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [14:0] echo_us_first, [29:15] echo_us_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] estimate_centi_cm, [26:11] spread_now
    output logic        m_tuser,   // [0] belief_collapsed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    hbrf_state_t state_reg, state_next;

    // Configuration registers.
    logic [SIGMA_W-1:0] sigma_start_reg, sigma_floor_reg, sigma_ceil_reg;
    logic [SIGMA_W-1:0] widen_reg, narrow_reg;
    logic [2:0]         cfg_index;

    // Filter state.
    logic [SIGMA_W-1:0]   sigma_a_reg, sigma_b_reg;
    logic [BIN_COUNT-1:0] valid_reg;
    logic [WEIGHT_BITS-1:0] bmem [BIN_COUNT];
    logic [WEIGHT_W-1:0]    wmem [BIN_COUNT];
    logic [WEIGHT_BITS-1:0] bmem_q;
    logic [WEIGHT_W-1:0]    wmem_q;
    logic                   vld_q;

    // Per-item datapath.
    logic [ECHO_W-1:0]    echo_a_reg, echo_b_reg;
    logic [26:0]          dnum_a_reg, dnum_b_reg;
    logic [DIST_W-1:0]    d_a_reg, d_b_reg;
    logic [SQ_W:0]        sprod_a_reg, sprod_b_reg;
    logic [SQ_W-1:0]      sq_a_reg, sq_b_reg;
    logic [DEN_W-1:0]     den_a_reg, den_b_reg;
    logic [BIN_IDX_W-1:0] bin_reg;
    logic [X_W-1:0]       x_reg;
    logic [DDSQ_W-1:0]    ddsq_a_reg, ddsq_b_reg;
    logic [DIV_W-1:0]     num_a_reg, num_b_reg;
    logic                 over_a_reg, over_b_reg;
    logic [EXP_SUM_W-1:0] idx_reg;
    logic [EXP_VAL_W-1:0] rom_reg;
    logic [WEIGHT_BITS-1:0] belief_reg;
    logic [WEIGHT_BITS+EXP_VAL_W-1:0] wprod_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [EST_W-1:0]     est_reg;
    logic                 collapsed_reg;

    // Output register.
    logic               m_tvalid_reg;
    logic [EST_W-1:0]   m_est_reg;
    logic [SIGMA_W-1:0] m_spread_reg;
    logic               m_flag_reg;

    // Divider connections.
    div_ctl_t         div_ctl_a, div_ctl_b;
    logic [DIV_W-1:0] div_num_a, div_num_b, div_den_a, div_den_b;
    logic             div_done_a, div_done_b;
    logic [QUO_W-1:0] quo_a, quo_b;

    // Combinational helpers.
    logic                   last_bin;
    logic                   out_free;
    logic                   opposite;
    logic [SIGMA_W-1:0]     factor;
    logic [SIGMA_W-1:0]     sg_a, sg_b;
    logic [X_W-1:0]         dd_a, dd_b;
    logic [EXP_CAP_W-1:0]   term_a, term_b;
    logic [WEIGHT_BITS+EXP_VAL_W:0] wround;
    logic [WEIGHT_W-1:0]    w_cur;
    logic [WEIGHT_BITS-1:0] b_cur;
    logic [WEIGHT_BITS-1:0] bel_cur;
    logic [SUM_W-1:0]       est_full;
    logic [26:0]            echo_num_a, echo_num_b;
    logic [53:0]            dprod_a, dprod_b;

    function automatic logic [DIST_W-1:0] clamp_dist(input logic [QUO_W-1:0] q);
        logic [DIST_W-1:0] r;
        if (q < QUO_W'(DIST_LOW)) begin
            r = DIST_W'(DIST_LOW);
        end else if (q > QUO_W'(DIST_HIGH)) begin
            r = DIST_W'(DIST_HIGH);
        end else begin
            r = q[DIST_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [SIGMA_W-1:0] bound_sigma(input logic [SQ_W:0] p,
                                                       input logic [SIGMA_W-1:0] lo,
                                                       input logic [SIGMA_W-1:0] hi);
        logic [SQ_W-15:0]   v;
        logic [SIGMA_W-1:0] r;
        v = p[SQ_W:15];
        if (v < (SQ_W-14)'(lo)) begin
            r = lo;
        end else if (v > (SQ_W-14)'(hi)) begin
            r = hi;
        end else begin
            r = v[SIGMA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [EXP_CAP_W-1:0] cap_term(input logic over,
                                                      input logic [QUO_W-1:0] q);
        logic [EXP_CAP_W-1:0] r;
        if (over || (q > QUO_W'(EXP_ENTRIES))) begin
            r = EXP_CAP_W'(EXP_ENTRIES);
        end else begin
            r = q[EXP_CAP_W-1:0];
        end
        return r;
    endfunction

    assign last_bin = (bin_reg == BIN_IDX_W'(BIN_COUNT - 1));
    assign out_free = !m_tvalid_reg || m_tready;
    assign opposite = ((d_a_reg == DIST_W'(DIST_LOW)) && (d_b_reg == DIST_W'(DIST_HIGH))) ||
                      ((d_b_reg == DIST_W'(DIST_LOW)) && (d_a_reg == DIST_W'(DIST_HIGH)));
    assign factor   = opposite ? widen_reg : narrow_reg;
    // A zero sigma counts as one inside the exponent.
    assign sg_a     = (sigma_a_reg == '0) ? SIGMA_W'(1) : sigma_a_reg;
    assign sg_b     = (sigma_b_reg == '0) ? SIGMA_W'(1) : sigma_b_reg;
    assign dd_a     = (X_W'(d_a_reg) > x_reg) ? X_W'(d_a_reg) - x_reg : x_reg - X_W'(d_a_reg);
    assign dd_b     = (X_W'(d_b_reg) > x_reg) ? X_W'(d_b_reg) - x_reg : x_reg - X_W'(d_b_reg);
    assign term_a   = cap_term(over_a_reg, quo_a);
    assign term_b   = cap_term(over_b_reg, quo_b);
    assign wround   = (WEIGHT_BITS+EXP_VAL_W+1)'(wprod_reg) + (WEIGHT_BITS+EXP_VAL_W+1)'(1 << 29);
    assign w_cur    = wround[30 +: WEIGHT_W];
    assign b_cur    = (quo_a > QUO_W'(W_MAX)) ? WEIGHT_BITS'(W_MAX) : quo_a[WEIGHT_BITS-1:0];
    assign bel_cur  = vld_q ? bmem_q : WEIGHT_BITS'(UNIFORM_W);
    assign est_full = (sum_reg + SUM_W'(1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
    assign echo_num_a = 27'(echo_a_reg) * 27'(ECHO_SCALE) + 27'(ECHO_ROUND);
    assign echo_num_b = 27'(echo_b_reg) * 27'(ECHO_SCALE) + 27'(ECHO_ROUND);
    // The rounded echo product divided by 1000 through a scaled reciprocal.
    assign dprod_a    = 54'(dnum_a_reg) * 54'(DIST_RECIP);
    assign dprod_b    = 54'(dnum_b_reg) * 54'(DIST_RECIP);

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_start_reg <= SIGMA_START_RST;
            sigma_floor_reg <= SIGMA_FLOOR_RST;
            sigma_ceil_reg  <= SIGMA_CEIL_RST;
            widen_reg       <= WIDEN_RST;
            narrow_reg      <= NARROW_RST;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_index)
                CFG_SIGMA_START: sigma_start_reg <= pwdata[SIGMA_W-1:0];
                CFG_SIGMA_FLOOR: sigma_floor_reg <= pwdata[SIGMA_W-1:0];
                CFG_SIGMA_CEIL:  sigma_ceil_reg  <= pwdata[SIGMA_W-1:0];
                CFG_WIDEN:       widen_reg       <= pwdata[SIGMA_W-1:0];
                CFG_NARROW:      narrow_reg      <= pwdata[SIGMA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            CFG_SIGMA_START: prdata = 32'(sigma_start_reg);
            CFG_SIGMA_FLOOR: prdata = 32'(sigma_floor_reg);
            CFG_SIGMA_CEIL:  prdata = 32'(sigma_ceil_reg);
            CFG_WIDEN:       prdata = 32'(widen_reg);
            CFG_NARROW:      prdata = 32'(narrow_reg);
            default:         prdata = '0;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and divider control.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_ctl_a  = '{start: 1'b0, qbits: '0};
        div_ctl_b  = '{start: 1'b0, qbits: '0};
        div_num_a  = '0;
        div_num_b  = '0;
        div_den_a  = '0;
        div_den_b  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_DIST_GO;
                end
            end
            ST_DIST_GO:   state_next = ST_DIST_WAIT;
            ST_DIST_WAIT: state_next = ST_SIG_MUL;
            ST_SIG_MUL: state_next = ST_SIG_SET;
            ST_SIG_SET: state_next = ST_SQ;
            ST_SQ:      state_next = ST_DEN;
            ST_DEN:     state_next = ST_B_DD;
            ST_B_DD:    state_next = ST_B_NUM;
            ST_B_NUM:   state_next = ST_B_GO;
            ST_B_GO: begin
                div_ctl_a  = '{start: 1'b1, qbits: DIV_CNT_W'(EXP_CAP_W)};
                div_ctl_b  = '{start: 1'b1, qbits: DIV_CNT_W'(EXP_CAP_W)};
                div_num_a  = num_a_reg;
                div_num_b  = num_b_reg;
                div_den_a  = DIV_W'(den_a_reg);
                div_den_b  = DIV_W'(den_b_reg);
                state_next = ST_B_WAIT;
            end
            ST_B_WAIT: begin
                if (div_done_a && div_done_b) begin
                    state_next = ST_B_ROM;
                end
            end
            ST_B_ROM: state_next = ST_B_MUL;
            ST_B_MUL: state_next = ST_B_WR;
            ST_B_WR:  state_next = last_bin ? ST_TOT : ST_B_DD;
            ST_TOT:   state_next = (total_reg == '0) ? ST_E_RD : ST_N_RD;
            ST_N_RD:  state_next = ST_N_GO;
            ST_N_GO: begin
                div_ctl_a  = '{start: 1'b1, qbits: DIV_CNT_W'(WEIGHT_W)};
                div_num_a  = (DIV_W'(wmem_q) << WEIGHT_BITS) + DIV_W'(total_reg >> 1);
                div_den_a  = DIV_W'(total_reg);
                state_next = ST_N_WAIT;
            end
            ST_N_WAIT: begin
                if (div_done_a) begin
                    state_next = last_bin ? ST_E_RD : ST_N_RD;
                end
            end
            ST_E_RD:  state_next = ST_E_ACC;
            ST_E_ACC: state_next = last_bin ? ST_EST : ST_E_RD;
            ST_EST:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    hbrf_div u_div_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl_a),
        .num     (div_num_a),
        .den     (div_den_a),
        .done    (div_done_a),
        .quo     (quo_a)
    );

    hbrf_div u_div_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl_b),
        .num     (div_num_b),
        .den     (div_den_b),
        .done    (div_done_b),
        .quo     (quo_b)
    );

    // Sigmas and the valid bits of the belief memory; an entry that is not valid reads as
    // the uniform weight, so clearing the bits restores the uniform belief at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_a_reg <= SIGMA_START_RST;
            sigma_b_reg <= SIGMA_START_RST;
            valid_reg   <= '0;
        end else begin
            if (state_reg == ST_SIG_SET) begin
                sigma_a_reg <= bound_sigma(sprod_a_reg, sigma_floor_reg, sigma_ceil_reg);
                sigma_b_reg <= bound_sigma(sprod_b_reg, sigma_floor_reg, sigma_ceil_reg);
            end
            if ((state_reg == ST_TOT) && (total_reg == '0)) begin
                valid_reg <= '0;
            end else if ((state_reg == ST_N_WAIT) && div_done_a) begin
                valid_reg[bin_reg] <= 1'b1;
            end
        end
    end

    // Belief and weight memories, one registered read port each at the current bin.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_N_WAIT) && div_done_a) begin
            bmem[bin_reg] <= b_cur;
        end
        if (state_reg == ST_B_WR) begin
            wmem[bin_reg] <= w_cur;
        end
        bmem_q <= bmem[bin_reg];
        wmem_q <= wmem[bin_reg];
        vld_q  <= valid_reg[bin_reg];
    end

    // Per-item datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                echo_a_reg <= s_tdata[ECHO_W-1:0];
                echo_b_reg <= s_tdata[2*ECHO_W-1:ECHO_W];
            end
            ST_DIST_GO: begin
                dnum_a_reg <= echo_num_a;
                dnum_b_reg <= echo_num_b;
            end
            ST_DIST_WAIT: begin
                d_a_reg <= clamp_dist(QUO_W'(dprod_a >> DIST_RECIP_SHIFT));
                d_b_reg <= clamp_dist(QUO_W'(dprod_b >> DIST_RECIP_SHIFT));
            end
            ST_SIG_MUL: begin
                sprod_a_reg <= (SQ_W+1)'(sigma_a_reg) * (SQ_W+1)'(factor) + (SQ_W+1)'(1 << 14);
                sprod_b_reg <= (SQ_W+1)'(sigma_b_reg) * (SQ_W+1)'(factor) + (SQ_W+1)'(1 << 14);
            end
            ST_SQ: begin
                sq_a_reg  <= SQ_W'(sg_a) * SQ_W'(sg_a);
                sq_b_reg  <= SQ_W'(sg_b) * SQ_W'(sg_b);
                bin_reg   <= '0;
                x_reg     <= X_W'(DIST_LOW);
                total_reg <= '0;
            end
            ST_DEN: begin
                den_a_reg <= DEN_W'(sq_a_reg) * DEN_W'(DEN_SCALE);
                den_b_reg <= DEN_W'(sq_b_reg) * DEN_W'(DEN_SCALE);
            end
            ST_B_DD: begin
                ddsq_a_reg <= DDSQ_W'(dd_a) * DDSQ_W'(dd_a);
                ddsq_b_reg <= DDSQ_W'(dd_b) * DDSQ_W'(dd_b);
            end
            ST_B_NUM: begin
                num_a_reg <= ((DIV_W'(ddsq_a_reg) * DIV_W'(EXP_ENTRIES)) << EXP_NUM_SHIFT)
                             + DIV_W'(den_a_reg >> 1);
                num_b_reg <= ((DIV_W'(ddsq_b_reg) * DIV_W'(EXP_ENTRIES)) << EXP_NUM_SHIFT)
                             + DIV_W'(den_b_reg >> 1);
            end
            ST_B_GO: begin
                // A quotient at or beyond the table length only needs to be known as capped.
                over_a_reg <= (num_a_reg >= (DIV_W'(den_a_reg) << EXP_CAP_W));
                over_b_reg <= (num_b_reg >= (DIV_W'(den_b_reg) << EXP_CAP_W));
            end
            ST_B_WAIT: begin
                idx_reg <= EXP_SUM_W'(term_a) + EXP_SUM_W'(term_b);
            end
            ST_B_ROM: begin
                if (idx_reg < EXP_SUM_W'(EXP_ENTRIES)) begin
                    rom_reg <= EXP_ROM[idx_reg[EXP_ADDR_W-1:0]];
                end else begin
                    rom_reg <= '0;
                end
                belief_reg <= bel_cur;
            end
            ST_B_MUL: begin
                wprod_reg <= (WEIGHT_BITS+EXP_VAL_W)'(belief_reg) *
                             (WEIGHT_BITS+EXP_VAL_W)'(rom_reg);
            end
            ST_B_WR: begin
                total_reg <= total_reg + TOTAL_W'(w_cur);
                if (last_bin) begin
                    bin_reg <= '0;
                    x_reg   <= X_W'(DIST_LOW);
                end else begin
                    bin_reg <= bin_reg + BIN_IDX_W'(1);
                    x_reg   <= x_reg + X_W'(BIN_PITCH);
                end
            end
            ST_TOT: begin
                collapsed_reg <= (total_reg == '0);
                sum_reg       <= '0;
            end
            ST_N_WAIT: begin
                if (div_done_a) begin
                    if (last_bin) begin
                        bin_reg <= '0;
                        x_reg   <= X_W'(DIST_LOW);
                    end else begin
                        bin_reg <= bin_reg + BIN_IDX_W'(1);
                        x_reg   <= x_reg + X_W'(BIN_PITCH);
                    end
                end
            end
            ST_E_ACC: begin
                sum_reg <= sum_reg + SUM_W'(x_reg) * SUM_W'(bel_cur);
                bin_reg <= bin_reg + BIN_IDX_W'(1);
                x_reg   <= x_reg + X_W'(BIN_PITCH);
            end
            ST_EST: begin
                if (est_full < SUM_W'(DIST_LOW)) begin
                    est_reg <= EST_W'(DIST_LOW);
                end else if (est_full > SUM_W'(EST_MAX)) begin
                    est_reg <= EST_W'(EST_MAX);
                end else begin
                    est_reg <= est_full[EST_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Output register: holds one finished result until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_est_reg    <= est_reg;
            m_spread_reg <= sigma_a_reg;
            m_flag_reg   <= collapsed_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_spread_reg, m_est_reg};
    assign m_tuser  = m_flag_reg;

endmodule

FILE: rtl/hbrf_div.sv
// Restoring divider that produces one quotient bit per cycle.
module hbrf_div
    import hbrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctl_t         ctl,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsh_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic                 fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                cnt_reg <= ctl.qbits;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= num;
            dsh_reg <= den << (ctl.qbits - DIV_CNT_W'(1));
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
